// File: design/sslw_pkg.sv
// ----------------------------------------------------------------------------
// sslw_pkg
// Shared widths, reset values and register indexes of the setpoint step
// limiter and watchdog.
// ----------------------------------------------------------------------------
package sslw_pkg;

	localparam int POS_W  = 24;
	localparam int AGE_W  = 16;
	localparam int STEP_W = 23;
	localparam int MAG_W  = POS_W;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int ROOT_W = SUM_W / 2;
	localparam int PROD_W = MAG_W + STEP_W;
	localparam int AXES   = 3;

	localparam logic signed [POS_W-1:0] RST_X_MIN = 24'sd250000;
	localparam logic signed [POS_W-1:0] RST_X_MAX = 24'sd750000;
	localparam logic signed [POS_W-1:0] RST_Y_MIN = -24'sd450000;
	localparam logic signed [POS_W-1:0] RST_Y_MAX = 24'sd450000;
	localparam logic signed [POS_W-1:0] RST_Z_MIN = 24'sd60000;
	localparam logic signed [POS_W-1:0] RST_Z_MAX = 24'sd700000;
	localparam logic [STEP_W-1:0] RST_MAX_STEP    = 23'd250;
	localparam logic [AGE_W-1:0]  RST_STALE_LIMIT = 16'd100;
	localparam logic signed [POS_W-1:0] RST_POS_X = 24'sd450000;
	localparam logic signed [POS_W-1:0] RST_POS_Y = 24'sd0;
	localparam logic signed [POS_W-1:0] RST_POS_Z = 24'sd300000;

	typedef enum logic [2:0] {
		REG_X_MIN = 3'd0,
		REG_X_MAX = 3'd1,
		REG_Y_MIN = 3'd2,
		REG_Y_MAX = 3'd3,
		REG_Z_MIN = 3'd4,
		REG_Z_MAX = 3'd5,
		REG_MAX_STEP = 3'd6,
		REG_STALE_LIMIT = 3'd7
	} reg_idx_t;

	// Handshake between the sequencer and a serial arithmetic unit.
	typedef struct packed {
		logic start;
	} unit_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_rsp_t;

endpackage

// File: design/sslw_isqrt.sv
// ----------------------------------------------------------------------------
// sslw_isqrt
// Restoring integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sslw_isqrt
	import sslw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  unit_req_t         req,
	input  logic [SUM_W-1:0]  radicand,
	output unit_rsp_t         rsp,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [SUM_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W+1:0]  rem_n;
	logic [REM_W+1:0]  trial;

	assign rem_n = {rem_q, rad_q[SUM_W-1 -: 2]};
	assign trial = {{(REM_W + 2 - ROOT_W - 2){1'b0}}, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= REM_W'(rem_n - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign root     = root_q;

endmodule

// File: design/sslw_div.sv
// ----------------------------------------------------------------------------
// sslw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sslw_div
	import sslw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  unit_req_t         req,
	input  logic [PROD_W-1:0] dividend,
	input  logic [ROOT_W-1:0] divisor,
	output unit_rsp_t         rsp,
	output logic [MAG_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] quo_q;
	logic [ROOT_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W:0]   rem_n;

	assign rem_n = {rem_q, quo_q[PROD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (rem_n >= {1'b0, divisor}) begin
				rem_q <= ROOT_W'(rem_n - {1'b0, divisor});
				quo_q <= {quo_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_n[ROOT_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign quotient = quo_q[MAG_W-1:0];

endmodule

// File: design/setpoint_step_limiter_watchdog_core.sv
// ----------------------------------------------------------------------------
// setpoint_step_limiter_watchdog_core
// Holds an XYZ setpoint, watches its age, clamps the target into a box and
// limits the Euclidean step from the last command per control tick.
// ----------------------------------------------------------------------------
//
// Channel   | Direction | Payload
// ----------+-----------+----------------------------------------------------
// s_axis    | in        | tdata: target_x, target_y, target_z; tuser: flags
// m_axis    | out       | tdata: cmd_x, cmd_y, cmd_z; tuser: stale
// APB       | in        | eight configuration registers at 4*index
//
// A seed item holds the input through accept and store. Any other item
// holds it through accept, clamp, six passes through one shared 24x24
// multiplier, a bit-serial square root at two radicand bits per cycle
// and, when the step must be cut, three parallel bit-serial dividers at
// one quotient bit per cycle, and then the store.
// Reset is asynchronous and active low; it restores the registers, held
// setpoint, last command and age. A new item is taken while a finished
// result still waits on m_axis; only the final store waits for that slot.
// ----------------------------------------------------------------------------
module setpoint_step_limiter_watchdog_core
	import sslw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // target_x [23:0], target_y [47:24], target_z [71:48]
	input  logic [1:0]  s_axis_tuser,  // has_setpoint [0], seed [1]
	// Result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // cmd_x [23:0], cmd_y [47:24], cmd_z [71:48]
	output logic [0:0]  m_axis_tuser   // stale [0]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_MUL,
		ST_SQRT,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef logic signed [POS_W-1:0] pos_t;

	state_t state_q;

	// Configuration registers.
	pos_t              box_lo_q [AXES];
	pos_t              box_hi_q [AXES];
	logic [STEP_W-1:0] max_step_q;
	logic [AGE_W-1:0]  stale_limit_q;

	// Controller state kept across items.
	pos_t             held_q [AXES];
	pos_t             last_q [AXES];
	logic [AGE_W-1:0] age_q;

	// Per-item working registers.
	pos_t              tgt_q  [AXES];
	logic              dneg_q [AXES];
	logic [MAG_W-1:0]  mag_q  [AXES];
	logic [PROD_W-1:0] prod_q [AXES];
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   mul_q;
	logic [2:0]        mcnt_q;
	logic              stale_q;

	logic              out_valid_q;
	logic [71:0]       out_data_q;
	logic              out_stale_q;

	unit_req_t         sq_req;
	unit_rsp_t         sq_rsp;
	logic [ROOT_W-1:0] root;
	unit_req_t         dv_req;
	unit_rsp_t         dv_rsp [AXES];
	logic [MAG_W-1:0]  quo [AXES];
	logic              sq_start_q;
	logic              dv_start_q;

	logic              cfg_wr;
	logic [2:0]        cfg_idx;
	logic              in_acc;
	logic              out_free;
	logic              out_load;
	logic              stale_c;
	pos_t              in_tgt [AXES];
	pos_t              clamp_c [AXES];
	logic signed [POS_W:0] diff_c [AXES];
	logic [1:0]        msel;
	logic [MAG_W-1:0]  mul_a;
	logic [MAG_W-1:0]  mul_b;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[4:2];

	always_comb begin
		unique case (reg_idx_t'(cfg_idx))
			REG_X_MIN:       prdata = 32'(box_lo_q[0]);
			REG_X_MAX:       prdata = 32'(box_hi_q[0]);
			REG_Y_MIN:       prdata = 32'(box_lo_q[1]);
			REG_Y_MAX:       prdata = 32'(box_hi_q[1]);
			REG_Z_MIN:       prdata = 32'(box_lo_q[2]);
			REG_Z_MAX:       prdata = 32'(box_hi_q[2]);
			REG_MAX_STEP:    prdata = {9'd0, max_step_q};
			REG_STALE_LIMIT: prdata = {16'd0, stale_limit_q};
			default:         prdata = '0;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = (state_q == ST_FIN) && out_free;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_stale_q;

	// The age is already updated when the clamp stage runs.
	assign stale_c = age_q > stale_limit_q;

	// Clamp lanes: raise to the minimum first, then lower to the maximum, so
	// an inverted box yields its maximum.
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			in_tgt[i]  = pos_t'(s_axis_tdata[i*POS_W +: POS_W]);
			clamp_c[i] = stale_c ? last_q[i] : held_q[i];
			if (clamp_c[i] < box_lo_q[i]) clamp_c[i] = box_lo_q[i];
			if (clamp_c[i] > box_hi_q[i]) clamp_c[i] = box_hi_q[i];
			diff_c[i]  = (POS_W+1)'(clamp_c[i]) - (POS_W+1)'(last_q[i]);
		end
	end

	// Shared multiplier: passes 0-2 square the deltas, passes 3-5 scale them
	// by the step cap.
	always_comb begin
		msel = (mcnt_q < 3'd3) ? mcnt_q[1:0] : 2'(mcnt_q - 3'd3);
		unique case (msel)
			2'd0:    mul_a = mag_q[0];
			2'd1:    mul_a = mag_q[1];
			default: mul_a = mag_q[2];
		endcase
		mul_b = (mcnt_q < 3'd3) ? mul_a : MAG_W'(max_step_q);
	end

	assign sq_req.start = sq_start_q;
	assign dv_req.start = dv_start_q;

	sslw_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (sq_req),
		.radicand (sum_q),
		.rsp      (sq_rsp),
		.root     (root)
	);

	for (genvar g = 0; g < AXES; g++) begin : g_div
		sslw_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.req      (dv_req),
			.dividend (prod_q[g]),
			.divisor  (root),
			.rsp      (dv_rsp[g]),
			.quotient (quo[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			box_lo_q[0]   <= RST_X_MIN;
			box_hi_q[0]   <= RST_X_MAX;
			box_lo_q[1]   <= RST_Y_MIN;
			box_hi_q[1]   <= RST_Y_MAX;
			box_lo_q[2]   <= RST_Z_MIN;
			box_hi_q[2]   <= RST_Z_MAX;
			max_step_q    <= RST_MAX_STEP;
			stale_limit_q <= RST_STALE_LIMIT;
			held_q[0]     <= RST_POS_X;
			held_q[1]     <= RST_POS_Y;
			held_q[2]     <= RST_POS_Z;
			last_q[0]     <= RST_POS_X;
			last_q[1]     <= RST_POS_Y;
			last_q[2]     <= RST_POS_Z;
			age_q         <= '0;
			mcnt_q        <= '0;
			sq_start_q    <= 1'b0;
			dv_start_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// Single-cycle start pulses for the root unit and the dividers.
			sq_start_q <= (state_q == ST_MUL) && (mcnt_q == 3'd6);
			dv_start_q <= (state_q == ST_SQRT) && sq_rsp.done &&
			              (root > ROOT_W'(max_step_q));
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;

			if (cfg_wr) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_X_MIN:       box_lo_q[0]   <= pos_t'(pwdata[POS_W-1:0]);
					REG_X_MAX:       box_hi_q[0]   <= pos_t'(pwdata[POS_W-1:0]);
					REG_Y_MIN:       box_lo_q[1]   <= pos_t'(pwdata[POS_W-1:0]);
					REG_Y_MAX:       box_hi_q[1]   <= pos_t'(pwdata[POS_W-1:0]);
					REG_Z_MIN:       box_lo_q[2]   <= pos_t'(pwdata[POS_W-1:0]);
					REG_Z_MAX:       box_hi_q[2]   <= pos_t'(pwdata[POS_W-1:0]);
					REG_MAX_STEP:    max_step_q    <= pwdata[STEP_W-1:0];
					REG_STALE_LIMIT: stale_limit_q <= pwdata[AGE_W-1:0];
					default:         ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser[1]) begin
							// Seed: load without limiting.
							for (int i = 0; i < AXES; i++) begin
								held_q[i] <= in_tgt[i];
								last_q[i] <= in_tgt[i];
								tgt_q[i]  <= in_tgt[i];
							end
							age_q   <= '0;
							stale_q <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							if (s_axis_tuser[0]) begin
								for (int i = 0; i < AXES; i++) held_q[i] <= in_tgt[i];
								age_q <= '0;
							end else if (age_q != '1) begin
								age_q <= age_q + 1'b1;
							end
							state_q <= ST_CLAMP;
						end
					end
				end
				ST_CLAMP: begin
					stale_q <= stale_c;
					for (int i = 0; i < AXES; i++) begin
						tgt_q[i]  <= clamp_c[i];
						dneg_q[i] <= diff_c[i][POS_W];
						mag_q[i]  <= diff_c[i][POS_W] ? MAG_W'(-diff_c[i])
						                              : MAG_W'(diff_c[i]);
					end
					sum_q   <= '0;
					mcnt_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					mul_q  <= mul_a * mul_b;
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q != 3'd0) begin
						unique case (mcnt_q)
							3'd1, 3'd2, 3'd3: sum_q <= sum_q + SUM_W'(mul_q);
							3'd4:             prod_q[0] <= mul_q[PROD_W-1:0];
							3'd5:             prod_q[1] <= mul_q[PROD_W-1:0];
							default:          prod_q[2] <= mul_q[PROD_W-1:0];
						endcase
					end
					if (mcnt_q == 3'd6) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq_rsp.done) begin
						if (root > ROOT_W'(max_step_q)) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIV: begin
					if (dv_rsp[0].done) begin
						for (int i = 0; i < AXES; i++) begin
							tgt_q[i] <= dneg_q[i] ? last_q[i] - pos_t'(quo[i])
							                      : last_q[i] + pos_t'(quo[i]);
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						for (int i = 0; i < AXES; i++) begin
							last_q[i] <= tgt_q[i];
							out_data_q[i*POS_W +: POS_W] <= tgt_q[i];
						end
						out_stale_q <= stale_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// An accepted item closes the input until its result is stored.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("second item accepted while one is in work");

	// The dividers are only started when the step exceeds the cap.
	a_div_cut: assert property (@(posedge clk) disable iff (!arst_n)
		dv_start_q |-> (root > ROOT_W'(max_step_q)))
		else $error("step scaling started below the cap");

	// The root unit and the dividers never run together.
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sq_rsp.busy && dv_rsp[0].busy))
		else $error("root and divide units overlap");

	// A result is stored only into a free output slot.
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> out_valid_q)
		else $error("finished result not presented");

endmodule

// File: sim/sslw_checker.sv
// ----------------------------------------------------------------------------
// sslw_checker
// Watches both item channels and the APB port of the setpoint step limiter,
// keeps its own copy of the registers and state, predicts every command and
// compares each result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sslw_checker
	import sslw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,
	input  logic [0:0]  m_axis_tuser,
	output int          fail_count,
	output int          pending,
	output int          stale_seen,
	output int          capped_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [71:0] pos;
		logic        stale;
	} command_t;

	longint bound_lo[AXES], bound_hi[AXES];
	longint step_cap, age_limit;
	longint setpoint_q[AXES], command_q[AXES];
	longint age;
	command_t expected_cmds[$];

	function automatic longint sx(logic [POS_W-1:0] v);
		return longint'($signed(v));
	endfunction

	// Largest r with r*r <= s; s stays below 2^68 so 128-bit math is plenty.
	function automatic longint root_of(logic [127:0] s);
		logic [127:0] lo, hi, mid;
		lo = 0;
		hi = (128'd1 << 35) - 1;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (mid * mid <= s) lo = mid;
			else hi = mid - 1;
		end
		return longint'(lo);
	endfunction

	task automatic predict_tick(logic [71:0] data, logic [1:0] flags);
		longint tgt[AXES], d[AXES], mag, r, q;
		logic [127:0] sum;
		logic is_stale;
		command_t c;
		sum = 0;
		is_stale = 1'b0;
		for (int i = 0; i < AXES; i++) tgt[i] = sx(data[i*POS_W +: POS_W]);
		if (flags[1]) begin
			// Seed loads both stores directly, without clamp or limiting.
			for (int i = 0; i < AXES; i++) begin
				setpoint_q[i] = tgt[i];
				command_q[i] = tgt[i];
			end
			age = 0;
		end else begin
			if (flags[0]) begin
				for (int i = 0; i < AXES; i++) setpoint_q[i] = tgt[i];
				age = 0;
			end else if (age < (1 << AGE_W) - 1) begin
				age++;
			end
			is_stale = age > age_limit;
			for (int i = 0; i < AXES; i++) begin
				tgt[i] = is_stale ? command_q[i] : setpoint_q[i];
				if (tgt[i] < bound_lo[i]) tgt[i] = bound_lo[i];
				if (tgt[i] > bound_hi[i]) tgt[i] = bound_hi[i];
				d[i] = tgt[i] - command_q[i];
				mag = d[i] < 0 ? -d[i] : d[i];
				sum += 128'(mag) * 128'(mag);
			end
			r = root_of(sum);
			if (r > step_cap) begin
				capped_seen++;
				for (int i = 0; i < AXES; i++) begin
					mag = d[i] < 0 ? -d[i] : d[i];
					q = (mag * step_cap) / r;
					tgt[i] = command_q[i] + (d[i] < 0 ? -q : q);
				end
			end
			for (int i = 0; i < AXES; i++) command_q[i] = tgt[i];
		end
		for (int i = 0; i < AXES; i++) c.pos[i*POS_W +: POS_W] = tgt[i][POS_W-1:0];
		c.stale = is_stale;
		if (is_stale) stale_seen++;
		expected_cmds.push_back(c);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_lo = '{250000, -450000, 60000};
			bound_hi = '{750000, 450000, 700000};
			step_cap = 250;
			age_limit = 100;
			setpoint_q = '{450000, 0, 300000};
			command_q = '{450000, 0, 300000};
			age = 0;
			expected_cmds.delete();
			fail_count = 0;
			stale_seen = 0;
			capped_seen = 0;
		end else begin
			if (psel && penable && pwrite) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_X_MIN:       bound_lo[0] = sx(pwdata[POS_W-1:0]);
					REG_X_MAX:       bound_hi[0] = sx(pwdata[POS_W-1:0]);
					REG_Y_MIN:       bound_lo[1] = sx(pwdata[POS_W-1:0]);
					REG_Y_MAX:       bound_hi[1] = sx(pwdata[POS_W-1:0]);
					REG_Z_MIN:       bound_lo[2] = sx(pwdata[POS_W-1:0]);
					REG_Z_MAX:       bound_hi[2] = sx(pwdata[POS_W-1:0]);
					REG_MAX_STEP:    step_cap = pwdata[STEP_W-1:0];
					REG_STALE_LIMIT: age_limit = pwdata[AGE_W-1:0];
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				command_t e;
				if (expected_cmds.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result item: cmd %h stale %b",
							m_axis_tdata, m_axis_tuser[0]);
				end else begin
					e = expected_cmds.pop_front();
					for (int i = 0; i < AXES; i++) begin
						if (m_axis_tdata[i*POS_W +: POS_W] !== e.pos[i*POS_W +: POS_W]) begin
							fail_count++;
							if (fail_count <= 10)
								$display("axis %0d mismatch: expected %0d got %0d", i,
									$signed(e.pos[i*POS_W +: POS_W]),
									$signed(m_axis_tdata[i*POS_W +: POS_W]));
						end
					end
					if (m_axis_tuser[0] !== e.stale) begin
						fail_count++;
						if (fail_count <= 10)
							$display("stale mismatch: expected %b got %b", e.stale,
								m_axis_tuser[0]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) predict_tick(s_axis_tdata, s_axis_tuser);
		end
		pending = expected_cmds.size();
	end
endmodule

// File: sim/tb_setpoint_step_limiter_watchdog_core.sv
// ----------------------------------------------------------------------------
// tb_setpoint_step_limiter_watchdog_core
// Drives control ticks and register writes into the step limiter with random
// gaps on both channels; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_setpoint_step_limiter_watchdog_core
	import sslw_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	int          fail_count, pending, stale_seen, capped_seen;
	int          ticks_sent;
	longint      cycle_count = 0;
	bit          stim_done = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	setpoint_step_limiter_watchdog_core dut (.*);

	sslw_checker u_checker (.*);

	// The receiver holds tready low for a random gap before taking each result.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 9);
			repeat (gap) @(posedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			m_axis_tready <= 1'b0;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1000000) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_tick(logic [1:0] flags, logic signed [POS_W-1:0] x,
		logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
		int gap;
		gap = $urandom_range(0, 9);
		repeat (gap) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= flags;
		s_axis_tdata <= {z, y, x};
		do @(posedge clk); while (!s_axis_tready);
		s_axis_tvalid <= 1'b0;
		ticks_sent++;
	endtask

	// Lets every prediction drain and the last tick finish before touching registers.
	task automatic wait_idle();
		do @(posedge clk); while (pending != 0);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic signed [POS_W-1:0] near(longint c, int spread);
		return POS_W'(c + $signed($urandom_range(0, 2 * spread)) - spread);
	endfunction

	task automatic random_tick(int spread);
		logic [1:0] flags;
		int r;
		r = $urandom_range(0, 99);
		// Mostly plain ticks and new setpoints, with a few seeds and full-range noise.
		flags = r < 5 ? 2'b10 : r < 8 ? 2'b11 : r < 50 ? 2'b01 : 2'b00;
		if ($urandom_range(0, 19) == 0)
			send_tick(flags, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
		else
			send_tick(flags, near(450000, spread), near(0, spread), near(300000, spread));
	endtask

	initial begin
		ticks_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks: extremes, seeds and box edges at reset settings, then staleness under a short stale limit.
		send_tick(2'b00, 0, 0, 0);
		send_tick(2'b01, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		send_tick(2'b01, -24'sh800000, -24'sh800000, -24'sh800000);
		send_tick(2'b10, -24'sh800000, 24'sh7FFFFF, 0);
		send_tick(2'b11, 460000, 100, 300000);
		send_tick(2'b01, 460100, 100, 300000);
		send_tick(2'b01, 460000, 100, 300000);
		send_tick(2'b01, 460000, 100, 300000);
		wait_idle();
		write_reg(REG_STALE_LIMIT, 2);
		write_reg(REG_MAX_STEP, 0);
		send_tick(2'b01, 500000, 1000, 400000);
		repeat (4) send_tick(2'b00, 0, 0, 0);
		wait_idle();
		// Inverted box on x and y: the maximum wins there; z spans the full range.
		write_reg(REG_X_MIN, 100);
		write_reg(REG_X_MAX, -100);
		write_reg(REG_Y_MIN, 24'h7FFFFF);
		write_reg(REG_Y_MAX, 24'h800000);
		write_reg(REG_Z_MIN, 24'h800000);
		write_reg(REG_Z_MAX, 24'h7FFFFF);
		write_reg(REG_MAX_STEP, 23'h7FFFFF);
		write_reg(REG_STALE_LIMIT, 16'hFFFF);
		send_tick(2'b01, 5000, -5000, 24'sh7FFFFF);
		send_tick(2'b00, 0, 0, 0);
		send_tick(2'b01, -24'sh800000, 24'sh7FFFFF, -24'sh800000);
		wait_idle();

		// Random phases, each under a different register setting.
		for (int phase = 0; phase < 8; phase++) begin
			write_reg(REG_X_MIN, near(300000, 200000));
			write_reg(REG_X_MAX, near(600000, 200000));
			write_reg(REG_Y_MIN, near(-300000, 200000));
			write_reg(REG_Y_MAX, near(300000, 200000));
			write_reg(REG_Z_MIN, near(100000, 200000));
			write_reg(REG_Z_MAX, near(500000, 200000));
			write_reg(REG_MAX_STEP, phase == 0 ? 0 : phase == 7 ? 23'h7FFFFF :
				$urandom_range(1, 1 << (3 * phase)));
			write_reg(REG_STALE_LIMIT, phase == 1 ? 0 : phase == 6 ? 16'hFFFF :
				$urandom_range(0, 8));
			repeat (235) random_tick(phase < 4 ? 2000 : 600000);
			wait_idle();
		end
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		$display("Sent %0d ticks through reset and eight register settings.", ticks_sent);
		$display("Saw %0d stale commands and %0d step-capped commands.", stale_seen,
			capped_seen);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
